[rtl/core/yrgb_pkg.sv]
// Shared types, constants and coefficient table of the YCbCr to RGB pixel packer.
package yrgb_pkg;

   // Fixed-point constants of the conversion
   localparam int LUMA_GAIN   = 76309;
   localparam int ROUND_HALF  = 32768;
   localparam int CHROMA_MID  = 128;
   localparam int LUMA_BLACK  = 16;
   localparam int DIV_HALF    = LUMA_GAIN / 2;

   // Reciprocal of LUMA_GAIN for the rounded chroma offset division
   localparam int      RECIP_SHIFT = 32;
   localparam int      RECIP_W     = 16;
   localparam longint  RECIP_MUL   = (longint'(1) <<< RECIP_SHIFT) / LUMA_GAIN;

   // Field and datapath widths
   localparam int PIX_W    = 8;
   localparam int WORD_W   = 24;
   localparam int COEF_W   = 18;
   localparam int MAG_W    = COEF_W + PIX_W;
   localparam int PROD_W   = MAG_W + RECIP_W;
   localparam int QUO_W    = 8;
   localparam int OFF_W    = 10;
   localparam int X_W      = 11;
   localparam int T_W      = 28;
   localparam int CH_SHIFT = 16;

   // Chroma product lanes
   localparam int NUM_LANES = 4;
   localparam int LANE_R    = 0;
   localparam int LANE_B    = 1;
   localparam int LANE_GU   = 2;
   localparam int LANE_GV   = 3;

   // Color channels
   localparam int NUM_CH = 3;
   localparam int CH_R   = 0;
   localparam int CH_G   = 1;
   localparam int CH_B   = 2;

   // Back-end pipeline depth
   localparam int BACK_STAGES = 5;

   // Queue between front and back
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_FORMAT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_SELECT = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  MATRIX_RESET      = 3'd6;

   typedef enum logic [2:0] {
      FMT_32RGB = 3'd0,
      FMT_32BGR = 3'd1,
      FMT_24RGB = 3'd2,
      FMT_24BGR = 3'd3,
      FMT_16RGB = 3'd4,
      FMT_16BGR = 3'd5,
      FMT_15RGB = 3'd6,
      FMT_15BGR = 3'd7
   } yrgb_format_type;

   typedef struct packed {
      logic [COEF_W-1:0] crv;
      logic [COEF_W-1:0] cbu;
      logic [COEF_W-1:0] cgu;
      logic [COEF_W-1:0] cgv;
   } yrgb_coef_type;

   // One pixel after the front end: luma plus chroma product magnitudes and signs
   typedef struct packed {
      logic [PIX_W-1:0]                     luma;
      logic [NUM_LANES-1:0]                 neg;
      logic [NUM_LANES-1:0][MAG_W-1:0]      mag;
   } yrgb_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } yrgb_queue_status_type;

   function automatic yrgb_coef_type coef_lookup(input logic [2:0] sel);
      yrgb_coef_type c;
      case (sel)
         3'd0, 3'd1: c = '{crv: 18'd117504, cbu: 18'd138453, cgu: 18'd13954, cgv: 18'd34903};
         3'd4:       c = '{crv: 18'd104448, cbu: 18'd132798, cgu: 18'd24759, cgv: 18'd53109};
         3'd7:       c = '{crv: 18'd117579, cbu: 18'd136230, cgu: 18'd16907, cgv: 18'd35559};
         default:    c = '{crv: 18'd104597, cbu: 18'd132201, cgu: 18'd25675, cgv: 18'd53279};
      endcase
      return c;
   endfunction

endpackage

[rtl/core/yrgb_front.sv]
// Front end: takes pixels, centers chroma and forms the four chroma products.
module yrgb_front
   import yrgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [PIX_W-1:0]      req_luma,
   input  logic [PIX_W-1:0]      req_chroma_blue,
   input  logic [PIX_W-1:0]      req_chroma_red,
   input  logic [2:0]            matrix_select,
   input  yrgb_queue_status_type queue_status,
   output logic                  item_valid,
   output yrgb_item_type         item
);

   logic          valid_ff, valid_in;
   yrgb_item_type item_ff, item_in;
   yrgb_coef_type coef;
   logic          accept;
   logic          u_neg, v_neg;
   logic [PIX_W-1:0] u_abs, v_abs;

   assign req_full   = valid_ff && queue_status.full;
   assign accept     = req_push && !req_full;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      coef  = coef_lookup(matrix_select);
      // Below mid-scale the centered chroma is negative
      u_neg = !req_chroma_blue[PIX_W-1];
      v_neg = !req_chroma_red[PIX_W-1];
      u_abs = u_neg ? PIX_W'(CHROMA_MID) - req_chroma_blue : {1'b0, req_chroma_blue[PIX_W-2:0]};
      v_abs = v_neg ? PIX_W'(CHROMA_MID) - req_chroma_red  : {1'b0, req_chroma_red[PIX_W-2:0]};

      item_in.luma          = req_luma;
      item_in.mag[LANE_R]   = MAG_W'(coef.crv) * MAG_W'(v_abs);
      item_in.mag[LANE_B]   = MAG_W'(coef.cbu) * MAG_W'(u_abs);
      item_in.mag[LANE_GU]  = MAG_W'(coef.cgu) * MAG_W'(u_abs);
      item_in.mag[LANE_GV]  = MAG_W'(coef.cgv) * MAG_W'(v_abs);
      // Green terms enter negated
      item_in.neg[LANE_R]   = v_neg;
      item_in.neg[LANE_B]   = u_neg;
      item_in.neg[LANE_GU]  = !u_neg;
      item_in.neg[LANE_GV]  = !v_neg;

      if (accept) begin
         valid_in = 1'b1;
      end else if (valid_ff && !queue_status.full) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

[rtl/core/yrgb_queue.sv]
// Short queue that decouples the front end from the back-end pipeline.
module yrgb_queue
   import yrgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  write_valid,
   input  yrgb_item_type         write_item,
   input  logic                  read_ready,
   output yrgb_item_type         read_item,
   output yrgb_queue_status_type status
);

   yrgb_item_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_write, do_read;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_write     = write_valid && !status.full;
   assign do_read      = read_ready && !status.empty;
   assign read_item    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_write ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_read  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      case ({do_write, do_read})
         2'b10:   count_in = count_ff + (QUEUE_AW+1)'(1);
         2'b01:   count_in = count_ff - (QUEUE_AW+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_ptr_ff] <= write_item;
      end
   end

endmodule

[rtl/core/yrgb_back.sv]
// Back end: rounded offset division, channel gain and clamp, and output packing.
module yrgb_back
   import yrgb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  yrgb_queue_status_type queue_status,
   input  yrgb_item_type         head_item,
   output logic                  queue_read,
   input  yrgb_format_type       output_format,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [WORD_W-1:0]     rsp_pixel_word
);

   localparam int LAST = BACK_STAGES - 1;

   logic [BACK_STAGES-1:0] valid_ff, valid_in, ready;

   // Stage 0: quotient estimate by reciprocal
   logic [MAG_W-1:0]   s1_nh_in [NUM_LANES];
   logic [PROD_W-1:0]  s1_prod  [NUM_LANES];
   logic [QUO_W-1:0]   s1_qa_in [NUM_LANES];
   logic [MAG_W-1:0]   s1_nh_ff [NUM_LANES];
   logic [QUO_W-1:0]   s1_qa_ff [NUM_LANES];
   logic [NUM_LANES-1:0] s1_neg_ff;
   logic [PIX_W-1:0]   s1_luma_ff;

   // Stage 1: quotient correction and sign
   logic [MAG_W-1:0]          s2_rem    [NUM_LANES];
   logic [QUO_W-1:0]          s2_q      [NUM_LANES];
   logic signed [OFF_W-1:0]   s2_qs     [NUM_LANES];
   logic signed [OFF_W-1:0]   s2_off_in [NUM_LANES];
   logic signed [OFF_W-1:0]   s2_off_ff [NUM_LANES];
   logic [PIX_W-1:0]          s2_luma_ff;

   // Stage 2: offset luma per channel
   logic signed [X_W-1:0]     s3_luma_s;
   logic signed [X_W-1:0]     s3_x_in [NUM_CH];
   logic signed [X_W-1:0]     s3_x_ff [NUM_CH];

   // Stage 3: gain, round and clamp
   logic signed [T_W-1:0]     s4_t [NUM_CH];
   logic [NUM_CH-1:0][PIX_W-1:0] s4_chan_in, s4_chan_ff;

   // Stage 4: packed word
   logic [PIX_W-1:0]  r, g, b;
   logic [WORD_W-1:0] word_in, word_ff;

   assign queue_read     = ready[0];
   assign rsp_empty      = !valid_ff[LAST];
   assign rsp_pixel_word = word_ff;

   // Each stage advances when it is empty or its successor advances
   always_comb begin
      ready[LAST] = !valid_ff[LAST] || rsp_pop;
      for (int k = LAST - 1; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = ready[0] ? !queue_status.empty : valid_ff[0];
      for (int k = 1; k < BACK_STAGES; k++) begin
         valid_in[k] = ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         s1_nh_in[k] = head_item.mag[k] + MAG_W'(DIV_HALF);
         s1_prod[k]  = PROD_W'(s1_nh_in[k]) * PROD_W'(RECIP_MUL);
         s1_qa_in[k] = s1_prod[k][RECIP_SHIFT +: QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_nh_ff   <= s1_nh_in;
         s1_qa_ff   <= s1_qa_in;
         s1_neg_ff  <= head_item.neg;
         s1_luma_ff <= head_item.luma;
      end
   end

   // The estimate is low by at most one: one compare fixes it
   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         s2_rem[k]    = s1_nh_ff[k] - MAG_W'(s1_qa_ff[k]) * MAG_W'(LUMA_GAIN);
         s2_q[k]      = s1_qa_ff[k] + QUO_W'(s2_rem[k] >= MAG_W'(LUMA_GAIN));
         s2_qs[k]     = signed'(OFF_W'(s2_q[k]));
         s2_off_in[k] = s1_neg_ff[k] ? -s2_qs[k] : s2_qs[k];
      end
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s2_off_ff  <= s2_off_in;
         s2_luma_ff <= s1_luma_ff;
      end
   end

   always_comb begin
      s3_luma_s     = signed'(X_W'(s2_luma_ff)) - X_W'(LUMA_BLACK);
      s3_x_in[CH_R] = s3_luma_s + X_W'(s2_off_ff[LANE_R]);
      s3_x_in[CH_B] = s3_luma_s + X_W'(s2_off_ff[LANE_B]);
      s3_x_in[CH_G] = s3_luma_s + X_W'(s2_off_ff[LANE_GU]) + X_W'(s2_off_ff[LANE_GV]);
   end

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         s3_x_ff <= s3_x_in;
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         s4_t[c] = T_W'(LUMA_GAIN) * T_W'(s3_x_ff[c]) + T_W'(ROUND_HALF);
         if (s4_t[c][T_W-1]) begin
            s4_chan_in[c] = '0;
         end else if (|s4_t[c][T_W-2:CH_SHIFT+PIX_W]) begin
            s4_chan_in[c] = '1;
         end else begin
            s4_chan_in[c] = s4_t[c][CH_SHIFT +: PIX_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready[3]) begin
         s4_chan_ff <= s4_chan_in;
      end
   end

   always_comb begin
      r = s4_chan_ff[CH_R];
      g = s4_chan_ff[CH_G];
      b = s4_chan_ff[CH_B];
      case (output_format)
         FMT_32RGB: word_in = {r, g, b};
         FMT_32BGR: word_in = {b, g, r};
         FMT_24RGB: word_in = {b, g, r};
         FMT_24BGR: word_in = {r, g, b};
         FMT_16RGB: word_in = {8'd0, r[7:3], g[7:2], b[7:3]};
         FMT_16BGR: word_in = {8'd0, b[7:3], g[7:2], r[7:3]};
         FMT_15RGB: word_in = {9'd0, r[7:3], g[7:3], b[7:3]};
         FMT_15BGR: word_in = {9'd0, b[7:3], g[7:3], r[7:3]};
         default:   word_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready[LAST]) begin
         word_ff <= word_in;
      end
   end

endmodule

[rtl/core/ycbcr_to_rgb_pixel_pack.sv]
// Top level of the YCbCr to RGB pixel converter and packer.
//
// Input side is a queue: drive req_luma, req_chroma_blue and req_chroma_red
// with req_push; a transfer happens on a clock edge with req_push high and
// req_full low. Result side is a queue too: rsp_pixel_word holds the oldest
// result while rsp_empty is low, and a transfer happens on an edge with
// rsp_pop high and rsp_empty low.
// One pixel is taken per cycle and one result leaves per cycle while the
// receiver keeps popping. A result reaches rsp_pixel_word through
// one front register, one queue slot and five back-end stages (reciprocal
// multiply, quotient correction, channel offset, gain and clamp, packing).
// When the receiver stops popping, the back-end stages fill, then the
// four-entry queue, then the front register, and only then req_full rises.
// Synchronous reset empties the pipeline and queue and sets output_format
// to 32-bit RGB and matrix_select to SMPTE 170M. The csr_ port writes a
// register on any edge with csr_write_enable high; write only while idle.
module ycbcr_to_rgb_pixel_pack
   import yrgb_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [PIX_W-1:0]       req_luma,
   input  logic [PIX_W-1:0]       req_chroma_blue,
   input  logic [PIX_W-1:0]       req_chroma_red,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [WORD_W-1:0]      rsp_pixel_word,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   yrgb_format_type       output_format_ff, output_format_in;
   logic [2:0]            matrix_select_ff, matrix_select_in;
   yrgb_queue_status_type queue_status;
   yrgb_item_type         front_item, head_item;
   logic                  front_valid;
   logic                  queue_read;

   always_comb begin
      output_format_in = output_format_ff;
      matrix_select_in = matrix_select_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_OUTPUT_FORMAT: output_format_in = yrgb_format_type'(csr_data);
            CSR_MATRIX_SELECT: matrix_select_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_format_ff <= FMT_32RGB;
         matrix_select_ff <= MATRIX_RESET;
      end else begin
         output_format_ff <= output_format_in;
         matrix_select_ff <= matrix_select_in;
      end
   end

   yrgb_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_luma        (req_luma),
      .req_chroma_blue (req_chroma_blue),
      .req_chroma_red  (req_chroma_red),
      .matrix_select   (matrix_select_ff),
      .queue_status    (queue_status),
      .item_valid      (front_valid),
      .item            (front_item)
   );

   yrgb_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .write_valid (front_valid),
      .write_item  (front_item),
      .read_ready  (queue_read),
      .read_item   (head_item),
      .status      (queue_status)
   );

   yrgb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_status   (queue_status),
      .head_item      (head_item),
      .queue_read     (queue_read),
      .output_format  (output_format_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_pixel_word (rsp_pixel_word)
   );

   // 16-bit layouts leave the top byte clear
   a_word_16_high_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (output_format_ff == FMT_16RGB || output_format_ff == FMT_16BGR))
      |-> (rsp_pixel_word[WORD_W-1:16] == '0))
      else $error("16-bit pixel word has high bits set");

   // 15-bit layouts leave bits 23:15 clear
   a_word_15_high_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (output_format_ff == FMT_15RGB || output_format_ff == FMT_15BGR))
      |-> (rsp_pixel_word[WORD_W-1:15] == '0))
      else $error("15-bit pixel word has high bits set");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(queue_status.full && queue_status.empty))
      else $error("queue reports full and empty at once");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("pipeline not empty after reset");

endmodule

[bench/tb_top.sv]
// Self-checking testbench of the YCbCr to RGB pixel packer: directed table, then random phases.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import yrgb_pkg::*;

   localparam int     CLOCK_HALF    = 6;
   localparam int     RESET_CYCLES  = 5;
   localparam int     CASE_COUNT    = 25;
   localparam int     RANDOM_PHASES = 12;
   localparam int     PHASE_PIXELS  = 120;
   localparam int     HOLD_AT       = 300;
   localparam int     HOLD_CYCLES   = 400;
   localparam int     DRAIN_CYCLES  = 24;
   localparam int     MAX_PRINTED   = 40;
   localparam int     RUN_LIMIT_NS  = 3_000_000;
   localparam longint GAIN          = 76309;
   localparam longint GAIN_HALF     = GAIN / 2;

   typedef struct packed {
      yrgb_format_type fmt;
      logic [2:0]      mtx;
      logic [7:0]      luma;
      logic [7:0]      cb;
      logic [7:0]      cr;
      logic            typed;
      logic [23:0]     word;
   } pixel_case_type;

   typedef struct packed {
      logic [23:0] word;
      logic [7:0]  luma;
      logic [7:0]  cb;
      logic [7:0]  cr;
   } pixel_expect_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_push         = 1'b0;
   logic                   req_full;
   logic [PIX_W-1:0]       req_luma         = '0;
   logic [PIX_W-1:0]       req_chroma_blue  = '0;
   logic [PIX_W-1:0]       req_chroma_red   = '0;
   logic                   rsp_empty;
   logic                   rsp_pop          = 1'b0;
   logic [WORD_W-1:0]      rsp_pixel_word;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_data         = '0;

   // Settings the block holds, mirrored here
   yrgb_format_type fmt_now    = FMT_32RGB;
   logic [2:0]      matrix_now = MATRIX_RESET;

   // Typed-in expectation that goes with the pixel on the input ports
   logic            drv_typed      = 1'b0;
   logic [23:0]     drv_typed_word = '0;

   pixel_expect_type pending_pixels[$];
   int               accepted_pixels = 0;
   int               error_count     = 0;
   pixel_case_type   directed_cases[CASE_COUNT];

   ycbcr_to_rgb_pixel_pack uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_luma         (req_luma),
      .req_chroma_blue  (req_chroma_blue),
      .req_chroma_red   (req_chroma_red),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_pixel_word   (rsp_pixel_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("[ycbcr_to_rgb_pixel_pack] ERROR");
      $finish;
   end

   // round(prod / GAIN), halves away from zero
   function automatic int rounded_offset(longint prod);
      if (prod > 0) begin
         return int'((prod + GAIN_HALF) / GAIN);
      end
      return -int'((-prod + GAIN_HALF) / GAIN);
   endfunction

   function automatic int channel_level(int y, int off);
      longint acc;
      acc = GAIN * longint'(y + off - 16) + 32768;
      if (acc < 0) begin
         return 0;
      end
      if (acc / 65536 > 255) begin
         return 255;
      end
      return int'(acc / 65536);
   endfunction

   function automatic logic [23:0] predict_pixel_word(yrgb_format_type fmt, logic [2:0] mtx,
                                                      logic [7:0] y8, logic [7:0] cb8,
                                                      logic [7:0] cr8);
      int          crv, cbu, cgu, cgv, u, v, r, g, b;
      logic [31:0] w;
      case (mtx)
         3'd0, 3'd1: begin
            crv = 117504; cbu = 138453; cgu = 13954; cgv = 34903;
         end
         3'd4: begin
            crv = 104448; cbu = 132798; cgu = 24759; cgv = 53109;
         end
         3'd7: begin
            crv = 117579; cbu = 136230; cgu = 16907; cgv = 35559;
         end
         default: begin
            crv = 104597; cbu = 132201; cgu = 25675; cgv = 53279;
         end
      endcase
      u = int'(cb8) - 128;
      v = int'(cr8) - 128;
      r = channel_level(int'(y8), rounded_offset(longint'(crv) * v));
      g = channel_level(int'(y8), rounded_offset(-longint'(cgu) * u)
                                  + rounded_offset(-longint'(cgv) * v));
      b = channel_level(int'(y8), rounded_offset(longint'(cbu) * u));
      case (fmt)
         FMT_32RGB: w = (r << 16) | (g << 8) | b;
         FMT_32BGR: w = (b << 16) | (g << 8) | r;
         FMT_24RGB: w = r | (g << 8) | (b << 16);
         FMT_24BGR: w = b | (g << 8) | (r << 16);
         FMT_16RGB: w = ((r >> 3) << 11) | ((g >> 2) << 5) | (b >> 3);
         FMT_16BGR: w = ((b >> 3) << 11) | ((g >> 2) << 5) | (r >> 3);
         FMT_15RGB: w = ((r >> 3) << 10) | ((g >> 3) << 5) | (b >> 3);
         default:   w = ((b >> 3) << 10) | ((g >> 3) << 5) | (r >> 3);
      endcase
      return w[23:0];
   endfunction

   task automatic report_mismatch(string detail);
      if (error_count < MAX_PRINTED) begin
         $display("%0t mismatch: %s", $realtime, detail);
      end
      error_count++;
   endtask

   // Record input transfers and check result transfers
   always @(posedge clock) begin
      pixel_expect_type item;
      pixel_expect_type want;
      if (!reset) begin
         if (req_push && !req_full) begin
            item.luma = req_luma;
            item.cb   = req_chroma_blue;
            item.cr   = req_chroma_red;
            item.word = drv_typed ? drv_typed_word
                      : predict_pixel_word(fmt_now, matrix_now, req_luma,
                                           req_chroma_blue, req_chroma_red);
            pending_pixels.push_back(item);
            accepted_pixels++;
         end
         if (rsp_pop && !rsp_empty) begin
            if (pending_pixels.size() == 0) begin
               report_mismatch($sformatf("pixel_word %06h with nothing pending",
                                         rsp_pixel_word));
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_pixel_word !== want.word) begin
                  report_mismatch($sformatf(
                     "pixel_word %06h, want %06h (Y %0d Cb %0d Cr %0d)",
                     rsp_pixel_word, want.word, want.luma, want.cb, want.cr));
               end
            end
         end
      end
   end

   // Receiver: rotating stall pattern, plus one long hold-off to back up the pipeline
   initial begin : pop_pattern
      int cyc;
      int mode;
      bit hold_done;
      cyc = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (!hold_done && accepted_pixels >= HOLD_AT) begin
            hold_done = 1;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode = (cyc / 53) % 4;
         case (mode)
            0:       rsp_pop <= 1'b1;
            1:       rsp_pop <= $urandom_range(0, 1);
            2:       rsp_pop <= (cyc % 4 == 0);
            default: rsp_pop <= ($urandom_range(0, 7) != 0);
         endcase
         cyc++;
      end
   end

   // Present one pixel from a falling edge and hold it until its transfer
   task automatic drive_pixel(logic [7:0] y8, logic [7:0] cb8, logic [7:0] cr8,
                              logic typed, logic [23:0] word);
      req_push        <= 1'b1;
      req_luma        <= y8;
      req_chroma_blue <= cb8;
      req_chroma_red  <= cr8;
      drv_typed      = typed;
      drv_typed_word = word;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   // Drop push and wait until every pending pixel has come out
   task automatic wait_idle();
      req_push <= 1'b0;
      do @(negedge clock); while (pending_pixels.size() != 0);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [2:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= value;
      if (idx == CSR_OUTPUT_FORMAT) begin
         fmt_now = yrgb_format_type'(value);
      end else begin
         matrix_now = value;
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly uniform, with a bias toward the corners of the range
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(0, 15))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'd16;
         3:       return 8'd235;
         4:       return 8'd128;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   initial begin : stimulus
      int remaining;
      int burst;
      int gap;
      yrgb_format_type fmt;
      logic [2:0] mtx;

      directed_cases = '{
         // reset settings: black, white, nominal black and white levels
         '{FMT_32RGB, 3'd6, 8'd0,   8'd128, 8'd128, 1'b1, 24'h000000},
         '{FMT_32RGB, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'hFFFFFF},
         '{FMT_32RGB, 3'd6, 8'd16,  8'd128, 8'd128, 1'b1, 24'h000000},
         '{FMT_32RGB, 3'd6, 8'd235, 8'd128, 8'd128, 1'b1, 24'hFFFFFF},
         // chroma at the extremes, both clamps
         '{FMT_32RGB, 3'd6, 8'd0,   8'd0,   8'd0,   1'b0, 24'h0},
         '{FMT_32RGB, 3'd6, 8'd255, 8'd255, 8'd255, 1'b0, 24'h0},
         // every layout
         '{FMT_32BGR, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'hFFFFFF},
         '{FMT_32BGR, 3'd6, 8'd90,  8'd60,  8'd200, 1'b0, 24'h0},
         '{FMT_24RGB, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'hFFFFFF},
         '{FMT_24RGB, 3'd6, 8'd90,  8'd200, 8'd60,  1'b0, 24'h0},
         '{FMT_24BGR, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'hFFFFFF},
         '{FMT_24BGR, 3'd6, 8'd170, 8'd85,  8'd170, 1'b0, 24'h0},
         '{FMT_16RGB, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'h00FFFF},
         '{FMT_16RGB, 3'd6, 8'd200, 8'd16,  8'd240, 1'b0, 24'h0},
         '{FMT_16BGR, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'h00FFFF},
         '{FMT_16BGR, 3'd6, 8'd40,  8'd240, 8'd16,  1'b0, 24'h0},
         '{FMT_15RGB, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'h007FFF},
         '{FMT_15BGR, 3'd6, 8'd255, 8'd128, 8'd128, 1'b1, 24'h007FFF},
         // every coefficient set
         '{FMT_32RGB, 3'd0, 8'd128, 8'd0,   8'd255, 1'b0, 24'h0},
         '{FMT_32RGB, 3'd1, 8'd128, 8'd255, 8'd0,   1'b0, 24'h0},
         '{FMT_32RGB, 3'd2, 8'd100, 8'd30,  8'd220, 1'b0, 24'h0},
         '{FMT_32RGB, 3'd3, 8'd180, 8'd220, 8'd30,  1'b0, 24'h0},
         '{FMT_32RGB, 3'd4, 8'd128, 8'd0,   8'd255, 1'b0, 24'h0},
         '{FMT_32RGB, 3'd5, 8'd60,  8'd127, 8'd129, 1'b0, 24'h0},
         '{FMT_32RGB, 3'd7, 8'd128, 8'd255, 8'd0,   1'b0, 24'h0}
      };

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_cases[i]) begin
         if (directed_cases[i].fmt != fmt_now || directed_cases[i].mtx != matrix_now) begin
            wait_idle();
            if (directed_cases[i].fmt != fmt_now) begin
               write_register(CSR_OUTPUT_FORMAT, directed_cases[i].fmt);
            end
            if (directed_cases[i].mtx != matrix_now) begin
               write_register(CSR_MATRIX_SELECT, directed_cases[i].mtx);
            end
         end
         drive_pixel(directed_cases[i].luma, directed_cases[i].cb, directed_cases[i].cr,
                     directed_cases[i].typed, directed_cases[i].word);
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0:       begin fmt = FMT_32RGB; mtx = 3'd0; end
            1:       begin fmt = FMT_15BGR; mtx = 3'd7; end
            default: begin
               fmt = yrgb_format_type'($urandom_range(0, 7));
               mtx = 3'($urandom_range(0, 7));
            end
         endcase
         wait_idle();
         write_register(CSR_OUTPUT_FORMAT, fmt);
         write_register(CSR_MATRIX_SELECT, mtx);

         remaining = PHASE_PIXELS;
         while (remaining > 0) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && remaining > 0; k++) begin
               drive_pixel(pick_sample(), pick_sample(), pick_sample(), 1'b0, 24'h0);
               remaining--;
            end
            // back-to-back bursts about a third of the time
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_push <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ycbcr_to_rgb_pixel_pack] OK");
      end else begin
         $display("[ycbcr_to_rgb_pixel_pack] ERROR");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/yrgb_pkg.sv
rtl/core/yrgb_front.sv
rtl/core/yrgb_queue.sv
rtl/core/yrgb_back.sv
rtl/core/ycbcr_to_rgb_pixel_pack.sv
bench/tb_top.sv
